### rtl/core/swss_pkg.sv
// ----------------------------------------------------------------------------
// swss_pkg
// Shared types and constants of the sliding-window sender store: slot and
// payload geometry, opcodes and the descriptor store control group.
// ----------------------------------------------------------------------------
package swss_pkg;

  // geometry
  localparam int WINDOW_SLOTS  = 64;
  localparam int PAYLOAD_WORDS = 256;
  localparam int SLOT_W        = $clog2(WINDOW_SLOTS);
  localparam int WORD_W        = $clog2(PAYLOAD_WORDS);
  localparam int PAY_ADDR_W    = SLOT_W + WORD_W;
  localparam int PAY_DEPTH     = 1 << PAY_ADDR_W;

  // field widths
  localparam int SEQ_W   = 32;
  localparam int DATA_W  = 64;
  localparam int LEN_W   = 12;
  localparam int WIDX_W  = 8;
  localparam int CFG_W   = 7;

  // window size after clamping, remainder before its final correction
  localparam int WS_W    = $clog2(WINDOW_SLOTS + 1);
  localparam int REM_W   = SLOT_W + 2;
  localparam int RECIP_W = SEQ_W + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_ACK   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  // control toward the descriptor store
  typedef struct packed {
    logic wr_en;
    logic ack_en;
    logic rd_en;
  } desc_ctrl_t;

endpackage

### rtl/core/swss_rem.sv
// ----------------------------------------------------------------------------
// swss_rem
// Window size register and slot index unit: seq mod window size through a
// reciprocal multiply, a low-bit back-multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module swss_rem import swss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              load_i,
  input  logic [SEQ_W-1:0]  seq_i,
  input  logic [SEQ_W-1:0]  seq_hold_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic [WS_W-1:0]   ws_o
);

  localparam int WS_RESET_EFF = (int'(CFG_RESET) > WINDOW_SLOTS) ? WINDOW_SLOTS :
                                (int'(CFG_RESET) == 0) ? 1 : int'(CFG_RESET);
  localparam logic [RECIP_W-1:0] RECIP_RESET =
    RECIP_W'(64'h1_0000_0000 / WS_RESET_EFF);

  logic [RECIP_W-1:0]          recip_tab [WINDOW_SLOTS+1];
  logic [WS_W-1:0]             ws_q, ws_d;
  logic [RECIP_W-1:0]          recip_q;
  logic [SEQ_W-1:0]            quot_q;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic [SEQ_W+RECIP_W-1:0]    prod;
  logic [REM_W-1:0]            ws_ext;

  // floor(2^32 / w) for every window size
  assign recip_tab[0] = '0;
  for (genvar g = 1; g <= WINDOW_SLOTS; g++) begin : g_recip
    localparam logic [RECIP_W-1:0] RecipVal = RECIP_W'(64'h1_0000_0000 / g);
    assign recip_tab[g] = RecipVal;
  end

  // clamp the written size into 1..WINDOW_SLOTS
  always_comb begin
    if (cfg_wdata_i == '0) begin
      ws_d = WS_W'(1);
    end else if (32'(cfg_wdata_i) > WINDOW_SLOTS) begin
      ws_d = WS_W'(WINDOW_SLOTS);
    end else begin
      ws_d = WS_W'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q    <= WS_W'(WS_RESET_EFF);
      recip_q <= RECIP_RESET;
    end else if (cfg_we_i) begin
      ws_q    <= ws_d;
      recip_q <= recip_tab[ws_d];
    end
  end

  // quotient estimate, at most one below the true quotient
  assign prod = (SEQ_W+RECIP_W)'(seq_i) * (SEQ_W+RECIP_W)'(recip_q);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quot_q <= prod[2*SEQ_W-1:SEQ_W];
    end
  end

  // remainder stays below twice the size, so low bits suffice
  assign ws_ext = REM_W'(ws_q);
  assign rem_d  = seq_hold_i[REM_W-1:0] - REM_W'(quot_q[REM_W-1:0] * ws_ext);

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  // final correction
  always_comb begin
    if (rem_q >= ws_ext) begin
      slot_o = SLOT_W'(rem_q - ws_ext);
    end else begin
      slot_o = SLOT_W'(rem_q);
    end
  end

  assign ws_o = ws_q;

endmodule

### rtl/core/swss_desc.sv
// ----------------------------------------------------------------------------
// swss_desc
// Slot descriptors: occupied flags and a sequence copy per slot for the
// cumulative acknowledge compare, plus a descriptor memory for slot reads.
// ----------------------------------------------------------------------------
module swss_desc import swss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  desc_ctrl_t        ctrl_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [SEQ_W-1:0]  seq_i,
  input  logic [LEN_W-1:0]  len_i,
  output logic              hit_o,
  output logic [LEN_W-1:0]  len_o
);

  logic [WINDOW_SLOTS-1:0]    occ_q;
  logic [SEQ_W-1:0]           cmp_seq_q [WINDOW_SLOTS];
  logic [SEQ_W+LEN_W-1:0]     desc_mem  [WINDOW_SLOTS];
  logic [SEQ_W+LEN_W-1:0]     rd_q;
  logic                       occ_rd_q;

  // occupied flags: set on packet completion, cleared by acknowledge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (ctrl_i.wr_en) begin
      occ_q[slot_i] <= 1'b1;
    end else if (ctrl_i.ack_en) begin
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        if (occ_q[i] && (cmp_seq_q[i] <= seq_i)) begin
          occ_q[i] <= 1'b0;
        end
      end
    end
  end

  // per-slot sequence copy for the acknowledge compare
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      cmp_seq_q[slot_i] <= seq_i;
    end
  end

  // descriptor memory, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      desc_mem[slot_i] <= {seq_i, len_i};
    end
    if (ctrl_i.rd_en) begin
      rd_q     <= desc_mem[slot_i];
      occ_rd_q <= occ_q[slot_i];
    end
  end

  assign hit_o = occ_rd_q && (rd_q[SEQ_W+LEN_W-1:LEN_W] == seq_i);
  assign len_o = rd_q[LEN_W-1:0];

endmodule

### rtl/core/swss_payload_ram.sv
// ----------------------------------------------------------------------------
// swss_payload_ram
// Payload word memory addressed by slot and word index, one port,
// registered read data.
// ----------------------------------------------------------------------------
module swss_payload_ram import swss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  re_i,
  input  logic [PAY_ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0]     wdata_i,
  output logic [DATA_W-1:0]     rdata_o
);

  logic [DATA_W-1:0] mem [PAY_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // read data registered, old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sliding_window_sender_store.sv
// ----------------------------------------------------------------------------
// sliding_window_sender_store
// A request passes the states MUL, RD and RSP, set by the two-step slot
// remainder and the registered read of the payload and descriptor memories;
// a new request is taken only in IDLE, after RSP has loaded the result.
// Reset clears slot occupancy, lower edge and packet count and sets the
// window size to 64; payload and descriptor memories are not cleared.
// ----------------------------------------------------------------------------
module sliding_window_sender_store import swss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [SEQ_W-1:0]  seq_num_i,
  input  logic [WIDX_W-1:0] word_index_i,
  input  logic [DATA_W-1:0] data_word_i,
  input  logic              last_word_i,
  input  logic [LEN_W-1:0]  byte_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [DATA_W-1:0] read_word_o,
  output logic [LEN_W-1:0]  read_byte_count_o,
  output logic              window_open_o,
  output logic [SEQ_W-1:0]  window_lower_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_RSP  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              accept;
  opcode_e           op_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [WIDX_W-1:0] widx_q;
  logic [DATA_W-1:0] data_q;
  logic              last_q;
  logic [LEN_W-1:0]  bytes_q;
  logic [SEQ_W-1:0]  lower_q, lower_d;
  logic [SEQ_W-1:0]  added_q, added_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q;
  logic [DATA_W-1:0] rword_q;
  logic [LEN_W-1:0]  rbytes_q;
  logic              wopen_q;
  logic [SEQ_W-1:0]  wlower_q;
  logic [SLOT_W-1:0] slot;
  logic [WS_W-1:0]   ws;
  logic              widx_ok;
  logic              pay_we;
  logic              pay_re;
  logic [DATA_W-1:0] pay_rdata;
  desc_ctrl_t        desc_ctrl;
  logic              desc_hit;
  logic [LEN_W-1:0]  desc_len;
  logic              rsp_load;
  logic              hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign widx_ok    = 32'(widx_q) < PAYLOAD_WORDS;

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_e'(opcode_i);
      seq_q   <= seq_num_i;
      widx_q  <= word_index_i;
      data_q  <= data_word_i;
      last_q  <= last_word_i;
      bytes_q <= byte_count_i;
    end
  end

  // slot index unit
  swss_rem u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .load_i      (accept),
    .seq_i       (seq_num_i),
    .seq_hold_i  (seq_q),
    .slot_o      (slot),
    .ws_o        (ws)
  );

  // memory access decode in the read stage
  always_comb begin
    desc_ctrl = '0;
    pay_we    = 1'b0;
    pay_re    = 1'b0;
    lower_d   = lower_q;
    added_d   = added_q;
    if (state_q == ST_RD) begin
      case (op_q)
        OP_STORE: begin
          pay_we          = widx_ok;
          desc_ctrl.wr_en = last_q;
          if (last_q) begin
            added_d = added_q + 1'b1;
          end
        end
        OP_ACK: begin
          desc_ctrl.ack_en = 1'b1;
          lower_d          = seq_q + 1'b1;
        end
        OP_READ: begin
          desc_ctrl.rd_en = 1'b1;
          pay_re          = widx_ok;
        end
        default: begin
        end
      endcase
    end
  end

  swss_desc u_desc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (desc_ctrl),
    .slot_i (slot),
    .seq_i  (seq_q),
    .len_i  (bytes_q),
    .hit_o  (desc_hit),
    .len_o  (desc_len)
  );

  swss_payload_ram u_pay (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .re_i    (pay_re),
    .addr_i  ({slot, WORD_W'(widx_q)}),
    .wdata_i (data_q),
    .rdata_o (pay_rdata)
  );

  // sequencer
  assign rsp_load = (state_q == ST_RSP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept)   state_d = ST_MUL;
      ST_MUL:                state_d = ST_RD;
      ST_RD:                 state_d = ST_RSP;
      ST_RSP:  if (rsp_load) state_d = ST_IDLE;
      default:               state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (rsp_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lower_q     <= '0;
      added_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lower_q     <= lower_d;
      added_q     <= added_d;
    end
  end

  // result register
  assign hit = (op_q == OP_READ) && desc_hit;

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      found_q  <= hit;
      rword_q  <= (hit && widx_ok) ? pay_rdata : '0;
      rbytes_q <= hit ? desc_len : '0;
      wopen_q  <= {1'b0, added_q} < ({1'b0, lower_q} + (SEQ_W+1)'(ws));
      wlower_q <= lower_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign found_o           = found_q;
  assign read_word_o       = rword_q;
  assign read_byte_count_o = rbytes_q;
  assign window_open_o     = wopen_q;
  assign window_lower_o    = wlower_q;

endmodule
